[hdl/lhm_pkg.sv]
// ----------------------------------------------------------------------------
// Latency histogram metrics table: shared types and constants
// Command codes, the input and result words, the layout of one table entry
// and the mapping of a latency onto its log2 bucket.
// ----------------------------------------------------------------------------
`default_nettype none

package lhm_pkg;

  localparam int CMD_W       = 3;
  localparam int METRIC_W    = 4;
  localparam int DATA_W      = 64;
  localparam int NUM_BUCKETS = 64;
  localparam int BKT_W       = 6;
  localparam int SCAN_W      = BKT_W + 1;
  localparam int DEC_BASE    = 10;
  localparam int REM_W       = 7;

  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ERROR    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GAUGE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OBSERVE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SNAPSHOT = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic [METRIC_W-1:0]        metric;
    logic [DATA_W-1:0]          amount;
    logic [DATA_W-1:0]          latency;
    logic signed [DATA_W-1:0]   gauge_value;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]          total_count;
    logic [DATA_W-1:0]          error_count;
    logic [DATA_W-1:0]          observed_count;
    logic signed [DATA_W-1:0]   gauge_out;
    logic [DATA_W-1:0]          median_estimate;
    logic [DATA_W-1:0]          tail_estimate;
  } out_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] errors;
    logic [DATA_W-1:0] obs;
    logic [DATA_W-1:0] gauge;
  } entry_t;

  // Bit length of the latency, capped at the last bucket; zero maps to bucket 0.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [DATA_W-1:0] lat);
    logic [BKT_W:0] len;
    len = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (lat[i] && ((lat >> (i + 1)) == '0)) begin
        len = len | (BKT_W + 1)'(i + 1);
      end
    end
    return (len >= (BKT_W + 1)'(NUM_BUCKETS - 1)) ? BKT_W'(NUM_BUCKETS - 1) : len[BKT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/lhm_ram.sv]
// ----------------------------------------------------------------------------
// Latency histogram metrics table: generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lhm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hdl/lhm_div100.sv]
// ----------------------------------------------------------------------------
// Latency histogram metrics table: divide by one hundred
// Two passes of a shift-and-add divide by ten on a 64-bit value, one add a
// cycle; a pass is seed, folds by 4, 8, 16 and 32, remainder and correction.
// ----------------------------------------------------------------------------
`default_nettype none

module lhm_div100
  import lhm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  output      logic              done,
  output      logic [DATA_W-1:0] quotient
);

  localparam logic [2:0] STEP_SEED   = 3'd0;
  localparam logic [2:0] STEP_FOLD4  = 3'd1;
  localparam logic [2:0] STEP_FOLD8  = 3'd2;
  localparam logic [2:0] STEP_FOLD16 = 3'd3;
  localparam logic [2:0] STEP_FOLD32 = 3'd4;
  localparam logic [2:0] STEP_REM    = 3'd5;
  localparam logic [2:0] STEP_FIX    = 3'd6;

  logic              busy_r;
  logic              done_r;
  logic              pass_r;
  logic [2:0]        step_r;
  logic [DATA_W-1:0] x_r;
  logic [DATA_W-1:0] q_r;
  logic [REM_W-1:0]  rem_r;
  logic [DATA_W-1:0] q_fix;

  assign q_fix = q_r + DATA_W'(rem_r >= REM_W'(DEC_BASE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pass_r <= 1'b0;
      step_r <= STEP_SEED;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pass_r <= 1'b0;
        step_r <= STEP_SEED;
      end else if (busy_r) begin
        if (step_r == STEP_FIX) begin
          step_r <= STEP_SEED;
          pass_r <= 1'b1;
          if (pass_r) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= dividend;
    end else if (busy_r) begin
      case (step_r)
        STEP_SEED: begin
          q_r <= (x_r >> 1) + (x_r >> 2);
        end
        STEP_FOLD4: begin
          q_r <= q_r + (q_r >> 4);
        end
        STEP_FOLD8: begin
          q_r <= q_r + (q_r >> 8);
        end
        STEP_FOLD16: begin
          q_r <= q_r + (q_r >> 16);
        end
        STEP_FOLD32: begin
          q_r <= (q_r + (q_r >> 32)) >> 3;
        end
        STEP_REM: begin
          rem_r <= REM_W'(x_r - ((q_r << 3) + (q_r << 1)));
        end
        default: begin
          x_r <= q_fix;
          q_r <= q_fix;
        end
      endcase
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

[hdl/latency_histogram_metrics_table_unit.sv]
// ----------------------------------------------------------------------------
// Latency histogram metrics table
// Add, error, gauge and observe words each take one RAM read and one write
// back, and no new word is taken until the write back is done.
// A snapshot of a metric with observations gives its result word after 14
// divider steps and then a bucket scan through the single bucket RAM read
// port; any other snapshot gives it straight after the table read.
// After reset a clearing pass over all NUM_METRICS * 64 bucket addresses
// zeroes both RAMs while no word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_histogram_metrics_table_unit
  import lhm_pkg::*;
#(
  parameter int NUM_METRICS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_word_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_word_t out_data
);

  localparam int SCL_AW    = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
  localparam int BKT_DEPTH = NUM_METRICS * NUM_BUCKETS;
  localparam int BKT_AW    = $clog2(BKT_DEPTH);
  localparam int ENTRY_W   = $bits(entry_t);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [BKT_AW-1:0]       clr_cnt_r;
  logic [BKT_AW-1:0]       clr_shift;
  in_word_t                item_r;
  logic                    ok_r;
  logic [SCL_AW-1:0]       idx_r;
  logic [BKT_AW-1:0]       baddr_r;
  entry_t                  snap_r;
  logic [DATA_W-1:0]       t50_r, t99_r, sum_r, sum_nxt;
  logic [SCAN_W-1:0]       scan_cnt_r;
  logic [SCAN_W-1:0]       scan_pos;
  logic                    f50_r, f99_r;
  logic [BKT_W-1:0]        i50_r, i99_r;
  logic                    out_valid_r;
  out_word_t               out_data_r;

  logic                    accept;
  logic                    in_ok;
  logic [SCL_AW-1:0]       in_idx;
  logic [SCL_AW+BKT_W-1:0] in_bfull, scan_bfull;
  logic [BKT_AW-1:0]       in_baddr;

  logic                    scl_we, bkt_we, upd_we;
  logic [SCL_AW-1:0]       scl_waddr, scl_raddr;
  logic [ENTRY_W-1:0]      scl_wdata_bits, scl_rdata_bits;
  entry_t                  scl_rdata, upd_entry;
  logic [BKT_AW-1:0]       bkt_waddr, bkt_raddr;
  logic [DATA_W-1:0]       bkt_wdata, bkt_rdata;

  logic                    div_start, div_done;
  logic [DATA_W-1:0]       div_quo;
  logic                    load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign in_ok    = {{(32 - METRIC_W){1'b0}}, in_data.metric} < 32'(NUM_METRICS);
  assign in_idx   = SCL_AW'({{(32 - METRIC_W){1'b0}}, in_data.metric});
  assign in_bfull = {in_idx, bucket_of(in_data.latency)};
  assign in_baddr = in_bfull[BKT_AW-1:0];

  assign scan_bfull = {idx_r, scan_cnt_r[BKT_W-1:0]};
  assign scan_pos   = scan_cnt_r - 1'b1;
  assign clr_shift  = clr_cnt_r >> BKT_W;

  assign scl_rdata = entry_t'(scl_rdata_bits);

  always_comb begin
    upd_entry = scl_rdata;
    upd_we    = 1'b0;
    case (item_r.cmd)
      CMD_ADD: begin
        upd_entry.count = scl_rdata.count + item_r.amount;
        upd_we          = 1'b1;
      end
      CMD_ERROR: begin
        upd_entry.errors = scl_rdata.errors + 1'b1;
        upd_we           = 1'b1;
      end
      CMD_GAUGE: begin
        upd_entry.gauge = item_r.gauge_value;
        upd_we          = 1'b1;
      end
      CMD_OBSERVE: begin
        upd_entry.count = scl_rdata.count + 1'b1;
        upd_entry.obs   = scl_rdata.obs + 1'b1;
        upd_we          = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign scl_we         = (state_r == ST_CLEAR) || ((state_r == ST_UPD) && ok_r && upd_we);
  assign scl_waddr      = (state_r == ST_CLEAR) ? clr_shift[SCL_AW-1:0] : idx_r;
  assign scl_wdata_bits = (state_r == ST_CLEAR) ? '0 : ENTRY_W'(upd_entry);
  assign scl_raddr      = in_idx;

  assign bkt_we    = (state_r == ST_CLEAR) ||
                     ((state_r == ST_UPD) && ok_r && (item_r.cmd == CMD_OBSERVE));
  assign bkt_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : baddr_r;
  assign bkt_wdata = (state_r == ST_CLEAR) ? '0 : (bkt_rdata + 1'b1);
  assign bkt_raddr = (state_r == ST_SCAN) ? scan_bfull[BKT_AW-1:0] : in_baddr;

  lhm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_METRICS)
  ) u_scl_ram (
    .clk     (clk),
    .wr_en   (scl_we),
    .wr_addr (scl_waddr),
    .wr_data (scl_wdata_bits),
    .rd_addr (scl_raddr),
    .rd_data (scl_rdata_bits)
  );

  lhm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BKT_DEPTH)
  ) u_bkt_ram (
    .clk     (clk),
    .wr_en   (bkt_we),
    .wr_addr (bkt_waddr),
    .wr_data (bkt_wdata),
    .rd_addr (bkt_raddr),
    .rd_data (bkt_rdata)
  );

  assign div_start = (state_r == ST_UPD) && ok_r && (item_r.cmd == CMD_SNAPSHOT) &&
                     (scl_rdata.obs != '0);

  lhm_div100 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (scl_rdata.obs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign sum_nxt  = sum_r + bkt_rdata;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == BKT_AW'(BKT_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (item_r.cmd != CMD_SNAPSHOT) begin
          state_nxt = ST_IDLE;
        end else if (div_start) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == SCAN_W'(NUM_BUCKETS)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r  <= in_data;
      ok_r    <= in_ok;
      idx_r   <= in_idx;
      baddr_r <= in_baddr;
    end
    if ((state_r == ST_UPD) && (item_r.cmd == CMD_SNAPSHOT)) begin
      snap_r <= ok_r ? scl_rdata : '0;
      f50_r  <= 1'b0;
      f99_r  <= 1'b0;
    end
    if ((state_r == ST_DIV) && div_done) begin
      t50_r      <= (snap_r.obs >> 1) + DATA_W'(snap_r.obs[0]);
      t99_r      <= snap_r.obs - div_quo;
      sum_r      <= '0;
      scan_cnt_r <= '0;
    end
    if (state_r == ST_SCAN) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
      if (scan_cnt_r != '0) begin
        sum_r <= sum_nxt;
        if (!f50_r && (sum_nxt >= t50_r)) begin
          f50_r <= 1'b1;
          i50_r <= scan_pos[BKT_W-1:0];
        end
        if (!f99_r && (sum_nxt >= t99_r)) begin
          f99_r <= 1'b1;
          i99_r <= scan_pos[BKT_W-1:0];
        end
      end
    end
    if (load_out) begin
      out_data_r.total_count     <= snap_r.count;
      out_data_r.error_count     <= snap_r.errors;
      out_data_r.observed_count  <= snap_r.obs;
      out_data_r.gauge_out       <= snap_r.gauge;
      out_data_r.median_estimate <= f50_r ? (DATA_W'(1) << i50_r) : '0;
      out_data_r.tail_estimate   <= f99_r ? (DATA_W'(1) << i99_r) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[bench/latency_histogram_metrics_table_unit_tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the latency histogram metrics table unit
// A queue of command words feeds a clocked driver. Every word that the unit
// takes is also applied to a local copy of the metrics table, and each
// snapshot queues the word it should produce. A clocked monitor compares each
// result word field by field with the oldest one queued. Both sides idle and
// stall at random, apart from one steady stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_histogram_metrics_table_unit_tb
  import lhm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_METRICS = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 150;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  in_word_t  words_to_send [$];
  out_word_t snapshots_due [$];
  int unsigned words_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  logic [63:0]        tally [NUM_METRICS];
  logic [63:0]        faults [NUM_METRICS];
  logic [63:0]        seen [NUM_METRICS];
  logic signed [63:0] level [NUM_METRICS];
  logic [63:0]        hist [NUM_METRICS][NUM_BUCKETS];

  wire steady = (words_taken >= 300) && (words_taken < 450);

  latency_histogram_metrics_table_unit #(
    .NUM_METRICS(NUM_METRICS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned bucket_index(input logic [63:0] lat);
    int unsigned len;
    len = 0;
    for (int i = 0; i < 64; i++) begin
      if (lat[i]) begin
        len = i + 1;
      end
    end
    return (len > NUM_BUCKETS - 1) ? NUM_BUCKETS - 1 : len;
  endfunction

  function automatic logic [63:0] bucket_bound(input int unsigned m, input logic [63:0] target);
    logic [63:0] running;
    running = '0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      running = running + hist[m][i];
      if (running >= target) begin
        return 64'd1 << i;
      end
    end
    return '0;
  endfunction

  task automatic apply_command(input in_word_t w);
    out_word_t   snap;
    logic [63:0] n;
    logic [63:0] half_target;
    logic [63:0] tail_target;
    int unsigned m;
    m = w.metric;
    case (w.cmd)
      CMD_ADD: begin
        tally[m] = tally[m] + w.amount;
      end
      CMD_ERROR: begin
        faults[m] = faults[m] + 64'd1;
      end
      CMD_GAUGE: begin
        level[m] = w.gauge_value;
      end
      CMD_OBSERVE: begin
        hist[m][bucket_index(w.latency)] = hist[m][bucket_index(w.latency)] + 64'd1;
        tally[m] = tally[m] + 64'd1;
        seen[m] = seen[m] + 64'd1;
      end
      CMD_SNAPSHOT: begin
        snap = '0;
        n = seen[m];
        snap.total_count = tally[m];
        snap.error_count = faults[m];
        snap.observed_count = n;
        snap.gauge_out = level[m];
        if (n != 64'd0) begin
          half_target = (n >> 1) + {63'd0, n[0]};
          tail_target = 64'd99 * (n / 64'd100) + (64'd99 * (n % 64'd100) + 64'd99) / 64'd100;
          snap.median_estimate = bucket_bound(m, half_target);
          snap.tail_estimate = bucket_bound(m, tail_target);
        end
        snapshots_due.push_back(snap);
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH cycle %0d: %s got %h expected %h", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(in_data);
        words_taken <= words_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (words_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 16)) begin
          in_data <= words_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (snapshots_due.size() == 0) begin
          report_mismatch("result word with none expected, total_count",
                          out_data.total_count, '0);
        end else begin
          want = snapshots_due.pop_front();
          check_field("total_count", out_data.total_count, want.total_count);
          check_field("error_count", out_data.error_count, want.error_count);
          check_field("observed_count", out_data.observed_count,
                      want.observed_count);
          check_field("gauge_out", out_data.gauge_out, want.gauge_out);
          check_field("median_estimate", out_data.median_estimate, want.median_estimate);
          check_field("tail_estimate", out_data.tail_estimate, want.tail_estimate);
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 16);
    end
  end

  function automatic in_word_t make_word(input logic [CMD_W-1:0] cmd,
                                         input logic [METRIC_W-1:0] metric,
                                         input logic [63:0] amount,
                                         input logic [63:0] latency,
                                         input logic [63:0] gauge);
    in_word_t w;
    w.cmd = cmd;
    w.metric = metric;
    w.amount = amount;
    w.latency = latency;
    w.gauge_value = gauge;
    return w;
  endfunction

  task automatic wait_until_idle();
    while (words_to_send.size() != 0 || in_valid || snapshots_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic queue_random(input int unsigned count);
    in_word_t    w;
    int unsigned made;
    int unsigned pick;
    made = 0;
    while (made < count) begin
      w = make_word(CMD_ADD, '0, rand64(), rand64() >> $urandom_range(0, 64), rand64());
      w.metric = ($urandom_range(0, 1) == 1) ? METRIC_W'($urandom_range(0, 3))
                                             : METRIC_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        w.cmd = CMD_ADD;
      end else if (pick < 18) begin
        w.cmd = CMD_ERROR;
      end else if (pick < 26) begin
        w.cmd = CMD_GAUGE;
      end else if (pick < 72) begin
        w.cmd = CMD_OBSERVE;
      end else if (pick < 90) begin
        w.cmd = CMD_SNAPSHOT;
      end else begin
        w.cmd = CMD_SNAPSHOT + CMD_W'($urandom_range(1, 3));
      end
      made++;
      words_to_send.push_back(w);
    end
  endtask

  initial begin
    for (int m = 0; m < NUM_METRICS; m++) begin
      tally[m] = '0;
      faults[m] = '0;
      seen[m] = '0;
      level[m] = '0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        hist[m][b] = '0;
      end
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    words_to_send.push_back(make_word(CMD_SNAPSHOT, 4'd0, rand64(), rand64(), rand64()));
    words_to_send.push_back(make_word(CMD_SNAPSHOT, 4'd15, rand64(), rand64(), rand64()));
    words_to_send.push_back(make_word(CMD_ADD, 4'd0, '1, rand64(), rand64()));
    words_to_send.push_back(make_word(CMD_ADD, 4'd0, 64'd1, rand64(), rand64()));
    words_to_send.push_back(make_word(CMD_ADD, 4'd15, 64'h8000_0000_0000_0000, '0, '0));
    words_to_send.push_back(make_word(CMD_ERROR, 4'd0, rand64(), rand64(), rand64()));
    words_to_send.push_back(make_word(CMD_GAUGE, 4'd0, '0, '0, 64'h8000_0000_0000_0000));
    words_to_send.push_back(make_word(CMD_GAUGE, 4'd15, '1, '1, 64'h7fff_ffff_ffff_ffff));
    words_to_send.push_back(make_word(CMD_OBSERVE, 4'd0, rand64(), '0, rand64()));
    words_to_send.push_back(make_word(CMD_OBSERVE, 4'd0, rand64(), 64'd1, rand64()));
    words_to_send.push_back(make_word(CMD_OBSERVE, 4'd0, rand64(), '1, rand64()));
    words_to_send.push_back(make_word(CMD_OBSERVE, 4'd0, rand64(),
                                      64'h4000_0000_0000_0000, rand64()));
    words_to_send.push_back(make_word(CMD_OBSERVE, 4'd15, rand64(),
                                      64'h2000_0000_0000_0000, rand64()));
    words_to_send.push_back(make_word(CMD_SNAPSHOT + 3'd1, 4'd0, '1, '1, '1));
    words_to_send.push_back(make_word(CMD_SNAPSHOT + 3'd2, 4'd15, '1, '1, '1));
    words_to_send.push_back(make_word(CMD_SNAPSHOT + 3'd3, 4'd0, '1, '1, '1));
    words_to_send.push_back(make_word(CMD_SNAPSHOT, 4'd0, rand64(), rand64(), rand64()));
    words_to_send.push_back(make_word(CMD_SNAPSHOT, 4'd15, rand64(), rand64(), rand64()));
    words_to_send.push_back(make_word(CMD_GAUGE, 4'd3, '0, '0, '1));
    words_to_send.push_back(make_word(CMD_SNAPSHOT, 4'd3, rand64(), rand64(), rand64()));
    wait_until_idle();

    queue_random(350);
    wait_until_idle();
    queue_random(350);
    wait_until_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
